// File: hdl/lpmd_pkg.sv
// Package for the length-prefixed message deframer.
// Holds the word types of both channels and the parser phase codes.
// No dependencies; the top-level deframer uses it.
package lpmd_pkg;

    // Smallest accepted frame length: two length bytes and the target id.
    localparam int unsigned MIN_LEN = 3;

    // Offset of the first body byte, which is also the target id.
    localparam logic [7:0] BODY_START = 8'd2;

    // Offset reported with a rejection, the high length byte.
    localparam logic [7:0] HIGH_LEN_OFFSET = 8'd1;

    localparam logic STATUS_BODY   = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    typedef enum logic [2:0] {
        PH_LOW  = 3'b001,
        PH_HIGH = 3'b010,
        PH_BODY = 3'b100
    } t_phase;

    typedef struct packed {
        logic [7:0] rx_byte;
    } t_rx_word;

    typedef struct packed {
        logic       status;
        logic [7:0] data_byte;
        logic [7:0] byte_offset;
        logic [7:0] frame_length;
        logic [7:0] target_id;
        logic       last;
    } t_res_word;

endpackage

// File: hdl/lpmd_stream_if.sv
// Valid/ready stream channel used on both sides of the deframer.
// The payload type is a parameter; the word types come from lpmd_pkg.
interface lpmd_stream_if #(
    parameter type T = logic [7:0]
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/length_prefixed_message_deframer.sv
// Top level of the length-prefixed message deframer.
// Depends on lpmd_pkg (types, phase codes) and lpmd_stream_if (channels).
//
// The deframer takes one received serial byte per word on i_rx and hunts for
// a two-byte total-length field sent low byte first. A length in 3..MAX_LEN
// (and never above 255) opens a frame whose remaining bytes come out on o_res
// one word each, tagged with their offset (the body starts at offset 2), the
// frame length, the target id (frame byte 2) and a last flag on the final
// byte. Any other length produces a single rejection word carrying the high
// length byte at offset 1, and the parser goes back to hunting. Length bytes
// that are accepted produce no word. The block sustains one byte per clock
// while o_res is not stalled: a byte is captured in an input register, the
// parse step is a few narrow compares and an 8-bit increment, and the result
// lands in an output register. Both registers advance together, which lets
// a new byte enter while a finished word still waits for o_res.ready; only a
// stalled output holds the input back.
module length_prefixed_message_deframer #(
    parameter int unsigned MAX_LEN = 255
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    lpmd_stream_if.sink          i_rx,
    lpmd_stream_if.source        o_res
);

    // Effective upper length bound: frame lengths are 8 bits wide, so any
    // length above 255 is refused whatever MAX_LEN says.
    localparam int unsigned LenCap = (MAX_LEN < 255) ? MAX_LEN : 255;
    localparam logic [7:0]  LenCapByte = LenCap[7:0];
    localparam logic [7:0]  MinLenByte = lpmd_pkg::MIN_LEN[7:0];

    // Input register.
    logic                     r_in_vld;
    lpmd_pkg::t_rx_word       r_in;

    // Parser state.
    lpmd_pkg::t_phase         r_phase,   n_phase;
    logic [7:0]               r_len_lo,  n_len_lo;
    logic [7:0]               r_exp_len, n_exp_len;
    logic [7:0]               r_rcvd,    n_rcvd;
    logic [7:0]               r_id,      n_id;

    // Output register.
    logic                     r_out_vld;
    lpmd_pkg::t_res_word      r_out,     n_out;
    logic                     n_has_res;

    logic                     proc_go;
    logic                     len_ok;
    logic                     is_last;
    logic [8:0]               off_next;

    // The held byte is processed whenever the output register is free or is
    // being emptied this cycle.
    assign proc_go    = r_in_vld && (!r_out_vld || o_res.ready);
    assign i_rx.ready = !r_in_vld || proc_go;

    assign o_res.valid = r_out_vld;
    assign o_res.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_vld <= i_rx.valid;
        end
        if (i_rx.ready && i_rx.valid) begin
            r_in <= i_rx.data;
        end
    end

    // A length is good when the high byte is zero and the low byte lies in
    // MIN_LEN..LenCap.
    assign len_ok   = (r_in.rx_byte == 8'd0) && (r_len_lo >= MinLenByte)
                      && (r_len_lo <= LenCapByte);
    assign off_next = {1'b0, r_rcvd} + 9'd1;
    assign is_last  = off_next >= {1'b0, r_exp_len};

    always_comb begin
        n_phase   = r_phase;
        n_len_lo  = r_len_lo;
        n_exp_len = r_exp_len;
        n_rcvd    = r_rcvd;
        n_id      = r_id;
        n_has_res = 1'b0;
        n_out     = r_out;
        case (r_phase)
            lpmd_pkg::PH_HIGH: begin
                if (len_ok) begin
                    n_exp_len = r_len_lo;
                    n_rcvd    = lpmd_pkg::BODY_START;
                    n_id      = 8'd0;
                    n_phase   = lpmd_pkg::PH_BODY;
                end else begin
                    // Rejected length: report it and hunt again.
                    n_has_res          = 1'b1;
                    n_out.status       = lpmd_pkg::STATUS_REJECT;
                    n_out.data_byte    = r_in.rx_byte;
                    n_out.byte_offset  = lpmd_pkg::HIGH_LEN_OFFSET;
                    n_out.frame_length = 8'd0;
                    n_out.target_id    = 8'd0;
                    n_out.last         = 1'b0;
                    n_phase            = lpmd_pkg::PH_LOW;
                    n_exp_len          = 8'd0;
                    n_rcvd             = 8'd0;
                end
            end
            lpmd_pkg::PH_BODY: begin
                // The first body byte names the target and is reported with
                // its own value as the id.
                if (r_rcvd == lpmd_pkg::BODY_START) begin
                    n_id = r_in.rx_byte;
                end
                n_has_res          = 1'b1;
                n_out.status       = lpmd_pkg::STATUS_BODY;
                n_out.data_byte    = r_in.rx_byte;
                n_out.byte_offset  = r_rcvd;
                n_out.frame_length = r_exp_len;
                n_out.target_id    = n_id;
                n_out.last         = is_last;
                if (is_last) begin
                    n_phase   = lpmd_pkg::PH_LOW;
                    n_exp_len = 8'd0;
                    n_rcvd    = 8'd0;
                    n_id      = 8'd0;
                end else begin
                    n_rcvd = off_next[7:0];
                end
            end
            default: begin
                // Waiting for the low length byte.
                n_len_lo = r_in.rx_byte;
                n_phase  = lpmd_pkg::PH_HIGH;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= lpmd_pkg::PH_LOW;
            r_exp_len <= 8'd0;
            r_rcvd    <= 8'd0;
            r_id      <= 8'd0;
            r_out_vld <= 1'b0;
        end else begin
            if (proc_go) begin
                r_phase   <= n_phase;
                r_exp_len <= n_exp_len;
                r_rcvd    <= n_rcvd;
                r_id      <= n_id;
                r_out_vld <= n_has_res;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
        if (proc_go) begin
            r_len_lo <= n_len_lo;
        end
        if (proc_go && n_has_res) begin
            r_out <= n_out;
        end
    end

    // A held byte that cannot move on stays put.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !proc_go |=> r_in_vld && $stable(r_in))
        else $error("input byte lost or changed while stalled");

    // Inside a frame the byte count stays between the body start and the
    // frame length.
    a_body_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == lpmd_pkg::PH_BODY |->
            r_rcvd >= lpmd_pkg::BODY_START && r_rcvd < r_exp_len)
        else $error("byte count outside the frame");

    // The last byte of a frame sends the parser back to hunting.
    a_last_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc_go && n_has_res && n_out.last |=> r_phase == lpmd_pkg::PH_LOW)
        else $error("parser did not return to hunting after the last byte");

    // A rejection word is only produced from the high length byte.
    a_reject_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc_go && n_has_res && n_out.status == lpmd_pkg::STATUS_REJECT |->
            r_phase == lpmd_pkg::PH_HIGH && !len_ok)
        else $error("rejection outside the length field");

endmodule
